FILE: rtl/core/component_health_breaker_table_unit_macros.svh
`ifndef COMPONENT_HEALTH_BREAKER_TABLE_UNIT_MACROS_SVH
`define COMPONENT_HEALTH_BREAKER_TABLE_UNIT_MACROS_SVH

// same-cycle implication on clk, off while in reset
`define CHBT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, off while in reset
`define CHBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/chbt_pkg.sv
`timescale 1ns / 1ps

package chbt_pkg;

	localparam int DEF_COMPONENTS  = 9;
	localparam int DEF_STREAK_BITS = 8;
	localparam int DEF_TIME_BITS   = 32;

	localparam logic [5:0]  DEFAULT_THRESHOLD = 6'd3;
	localparam logic [15:0] DEFAULT_TIMEOUT   = 16'd30000;

	localparam logic [2:0] CFG_CRITICAL_MASK  = 3'd0;
	localparam logic [2:0] CFG_THRESHOLDS     = 3'd1;
	localparam logic [2:0] CFG_TIMEOUTS_LOW   = 3'd2;
	localparam logic [2:0] CFG_TIMEOUTS_HIGH  = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT_LAST   = 3'd4;

	typedef enum logic [2:0] {
		OP_SUCCESS = 3'd0,
		OP_FAILURE = 3'd1,
		OP_ALLOW   = 3'd2,
		OP_RESET   = 3'd3,
		OP_INIT    = 3'd4,
		OP_FORCE   = 3'd5,
		OP_QUERY   = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		H_UNKNOWN   = 3'd0,
		H_HEALTHY   = 3'd1,
		H_DEGRADED  = 3'd2,
		H_UNHEALTHY = 3'd3,
		H_FAILED    = 3'd4
	} health_t;

	typedef enum logic [1:0] {
		C_CLOSED = 2'd0,
		C_OPEN   = 2'd1,
		C_HALF   = 2'd2
	} circuit_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [8:0]  critical_mask;
		logic [53:0] thresholds;
		logic [63:0] timeouts_low;
		logic [63:0] timeouts_high;
		logic [15:0] timeout_last;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic update;
		logic load_out;
	} cmd_t;

endpackage

FILE: rtl/core/chbt_regs.sv
`timescale 1ns / 1ps

module chbt_regs import chbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_mask <= 9'h00F;
			cfg_q.thresholds    <= {9{DEFAULT_THRESHOLD}};
			cfg_q.timeouts_low  <= {4{DEFAULT_TIMEOUT}};
			cfg_q.timeouts_high <= {4{DEFAULT_TIMEOUT}};
			cfg_q.timeout_last  <= DEFAULT_TIMEOUT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CRITICAL_MASK: cfg_q.critical_mask <= cfg_data[8:0];
				CFG_THRESHOLDS:    cfg_q.thresholds    <= cfg_data[53:0];
				CFG_TIMEOUTS_LOW:  cfg_q.timeouts_low  <= cfg_data;
				CFG_TIMEOUTS_HIGH: cfg_q.timeouts_high <= cfg_data;
				CFG_TIMEOUT_LAST:  cfg_q.timeout_last  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/chbt_ctrl.sv
`timescale 1ns / 1ps
`include "component_health_breaker_table_unit_macros.svh"

module chbt_ctrl import chbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n      = state_q;
		in_stall     = 1'b1;
		cmd.load_in  = 1'b0;
		cmd.update   = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_n    = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	`CHBT_ASSERT_NEXT(a_accept_starts_update, in_valid && !in_stall, state_q == S_UPDATE, "accepted word did not start an update")
	`CHBT_ASSERT_NEXT(a_update_to_emit, state_q == S_UPDATE, state_q == S_EMIT && !out_valid_q || state_q == S_EMIT && out_valid_q, "update not followed by emit")
	`CHBT_ASSERT_NEXT(a_emit_loads_result, state_q == S_EMIT && out_free, out_valid_q && state_q == S_IDLE, "emit did not present a result word")
	`CHBT_ASSERT_NOW(a_no_update_while_idle, cmd.update, state_q == S_UPDATE && in_stall, "table update outside update state")

endmodule

FILE: rtl/core/chbt_datapath.sv
`timescale 1ns / 1ps

module chbt_datapath import chbt_pkg::*; #(
	parameter int COMPONENTS  = DEF_COMPONENTS,
	parameter int STREAK_BITS = DEF_STREAK_BITS,
	parameter int TIME_BITS   = DEF_TIME_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  cfg_t        cfg,
	input  logic [2:0]  op,
	input  logic [3:0]  component,
	input  logic [31:0] now_ms,
	input  logic [2:0]  forced_health,
	output logic        id_valid,
	output logic        allowed,
	output logic [2:0]  comp_health,
	output logic [1:0]  comp_circuit,
	output logic [7:0]  fail_streak,
	output logic [2:0]  overall_health,
	output logic        control_ok,
	output logic        observe_ok,
	output logic [3:0]  healthy_total,
	output logic [3:0]  degraded_total,
	output logic [3:0]  unhealthy_total,
	output logic [3:0]  failed_total
);

	localparam int IW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
	localparam int CW = (STREAK_BITS > 6) ? STREAK_BITS : 6;
	localparam int SW = (STREAK_BITS > 8) ? STREAK_BITS : 8;

	health_t                health_q    [COMPONENTS];
	circuit_t               breaker_q   [COMPONENTS];
	logic [STREAK_BITS-1:0] streak_q    [COMPONENTS];
	logic [TIME_BITS-1:0]   fail_time_q [COMPONENTS];
	logic [COMPONENTS-1:0]  ready_q;
	logic                   allow_q;

	op_t                    op_q;
	logic [3:0]             comp_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [2:0]             forced_q;

	logic [5:0]             thr_arr [COMPONENTS];
	logic [15:0]            tmo_arr [COMPONENTS];

	logic                   id_ok;
	logic [IW-1:0]          idx;

	health_t                h_n;
	circuit_t               b_n;
	logic [STREAK_BITS-1:0] s_n;
	logic [TIME_BITS-1:0]   t_n;
	logic                   rdy_n;
	logic                   allow_n;

	logic [COMPONENTS-1:0]  is_healthy;
	logic [COMPONENTS-1:0]  is_degraded;
	logic [COMPONENTS-1:0]  is_unhealthy;
	logic [COMPONENTS-1:0]  is_failed;
	logic [COMPONENTS-1:0]  crit_bad;
	logic [COMPONENTS-1:0]  crit_failed;
	logic [SW-1:0]          streak_wide;

	for (genvar i = 0; i < COMPONENTS; i++) begin : g_cfg
		assign thr_arr[i] = cfg.thresholds[6*i +: 6];
		if (i < 4) begin : g_low
			assign tmo_arr[i] = cfg.timeouts_low[16*i +: 16];
		end else if (i < 8) begin : g_high
			assign tmo_arr[i] = cfg.timeouts_high[16*(i-4) +: 16];
		end else begin : g_last
			assign tmo_arr[i] = cfg.timeout_last;
		end
	end

	assign id_ok = comp_q < 4'(COMPONENTS);
	assign idx   = comp_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= op_t'(op);
			comp_q   <= component;
			now_q    <= TIME_BITS'(now_ms);
			forced_q <= forced_health;
		end
	end

	// event applied to the addressed entry
	always_comb begin
		health_t                h;
		circuit_t               b;
		logic [STREAK_BITS-1:0] s;
		logic [STREAK_BITS-1:0] s_inc;
		logic [5:0]             thr;
		logic [15:0]            tmo;
		logic [TIME_BITS-1:0]   elapsed;
		h       = health_q[idx];
		b       = breaker_q[idx];
		s       = streak_q[idx];
		thr     = (thr_arr[idx] == 6'd0) ? DEFAULT_THRESHOLD : thr_arr[idx];
		tmo     = (tmo_arr[idx] == 16'd0) ? DEFAULT_TIMEOUT : tmo_arr[idx];
		s_inc   = (&s) ? s : s + STREAK_BITS'(1);
		elapsed = now_q - fail_time_q[idx];
		h_n     = h;
		b_n     = b;
		s_n     = s;
		t_n     = fail_time_q[idx];
		rdy_n   = ready_q[idx];
		allow_n = 1'b0;
		unique case (op_q)
			OP_SUCCESS: begin
				s_n = '0;
				if (h == H_UNHEALTHY || h == H_UNKNOWN) begin
					h_n = H_HEALTHY;
				end
				if (b == C_HALF) begin
					b_n = C_CLOSED;
				end
			end
			OP_FAILURE: begin
				s_n = s_inc;
				t_n = now_q;
				if (CW'(s_inc) >= CW'(thr)) begin
					if (h != H_FAILED) begin
						h_n = H_UNHEALTHY;
						if (b == C_CLOSED) begin
							b_n = C_OPEN;
						end
					end
				end else if (h == H_HEALTHY) begin
					h_n = H_DEGRADED;
				end
				if (b == C_HALF) begin
					b_n = C_OPEN;
				end
			end
			OP_ALLOW: begin
				if (b == C_CLOSED) begin
					allow_n = 1'b1;
				end else if (b == C_OPEN && elapsed >= TIME_BITS'(tmo)) begin
					b_n     = C_HALF;
					allow_n = 1'b1;
				end
			end
			OP_RESET: begin
				b_n = C_CLOSED;
				s_n = '0;
			end
			OP_INIT: begin
				rdy_n = 1'b1;
				if (h == H_UNKNOWN) begin
					h_n = H_HEALTHY;
				end
			end
			OP_FORCE: begin
				if (forced_q <= H_FAILED) begin
					h_n = health_t'(forced_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMPONENTS; i++) begin
				health_q[i]    <= H_UNKNOWN;
				breaker_q[i]   <= C_CLOSED;
				streak_q[i]    <= '0;
				fail_time_q[i] <= '0;
			end
			ready_q <= '0;
			allow_q <= 1'b0;
		end else if (cmd.update) begin
			allow_q <= id_ok && allow_n;
			for (int i = 0; i < COMPONENTS; i++) begin
				if (id_ok && idx == IW'(i)) begin
					health_q[i]    <= h_n;
					breaker_q[i]   <= b_n;
					streak_q[i]    <= s_n;
					fail_time_q[i] <= t_n;
					ready_q[i]     <= rdy_n;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < COMPONENTS; i++) begin
			is_healthy[i]   = ready_q[i] && health_q[i] == H_HEALTHY;
			is_degraded[i]  = ready_q[i] && health_q[i] == H_DEGRADED;
			is_unhealthy[i] = ready_q[i] && health_q[i] == H_UNHEALTHY;
			is_failed[i]    = ready_q[i] && health_q[i] == H_FAILED;
			crit_bad[i]     = cfg.critical_mask[i] && (is_unhealthy[i] || is_failed[i]);
			crit_failed[i]  = cfg.critical_mask[i] && is_failed[i];
		end
	end

	assign streak_wide = SW'(streak_q[idx]);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			id_valid        <= id_ok;
			allowed         <= allow_q;
			comp_health     <= id_ok ? health_q[idx] : H_UNKNOWN;
			comp_circuit    <= id_ok ? breaker_q[idx] : C_OPEN;
			if (!id_ok) begin
				fail_streak <= 8'd0;
			end else if (streak_wide > SW'(8'hFF)) begin
				fail_streak <= 8'hFF;
			end else begin
				fail_streak <= streak_wide[7:0];
			end
			if (|is_failed) begin
				overall_health <= H_FAILED;
			end else if (|is_unhealthy) begin
				overall_health <= H_UNHEALTHY;
			end else if (|is_degraded) begin
				overall_health <= H_DEGRADED;
			end else begin
				overall_health <= H_HEALTHY;
			end
			control_ok      <= ~|crit_bad;
			observe_ok      <= ~|crit_failed;
			healthy_total   <= 4'($countones(is_healthy));
			degraded_total  <= 4'($countones(is_degraded));
			unhealthy_total <= 4'($countones(is_unhealthy));
			failed_total    <= 4'($countones(is_failed));
		end
	end

endmodule

FILE: rtl/core/component_health_breaker_table_unit.sv
// the accepted word goes through the update state, then the emit state, which loads the result
// register once it is free; a new word is accepted only in idle, set by the controller sequence
//   accept, table update, result load over the single table write port
// the result register lets the next word be accepted while a result waits
// reset: asynchronous, active low; tables return to unknown, closed, zero, not initialized
//   and configuration registers return to their default values
`timescale 1ns / 1ps

module component_health_breaker_table_unit import chbt_pkg::*; #(
	parameter int COMPONENTS  = DEF_COMPONENTS,
	parameter int STREAK_BITS = DEF_STREAK_BITS,
	parameter int TIME_BITS   = DEF_TIME_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [3:0]  component,
	input  logic [31:0] now_ms,
	input  logic [2:0]  forced_health,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        id_valid,
	output logic        allowed,
	output logic [2:0]  comp_health,
	output logic [1:0]  comp_circuit,
	output logic [7:0]  fail_streak,
	output logic [2:0]  overall_health,
	output logic        control_ok,
	output logic        observe_ok,
	output logic [3:0]  healthy_total,
	output logic [3:0]  degraded_total,
	output logic [3:0]  unhealthy_total,
	output logic [3:0]  failed_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t cfg;
	cmd_t cmd;

	chbt_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	chbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	chbt_datapath #(
		.COMPONENTS  (COMPONENTS),
		.STREAK_BITS (STREAK_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.op              (op),
		.component       (component),
		.now_ms          (now_ms),
		.forced_health   (forced_health),
		.id_valid        (id_valid),
		.allowed         (allowed),
		.comp_health     (comp_health),
		.comp_circuit    (comp_circuit),
		.fail_streak     (fail_streak),
		.overall_health  (overall_health),
		.control_ok      (control_ok),
		.observe_ok      (observe_ok),
		.healthy_total   (healthy_total),
		.degraded_total  (degraded_total),
		.unhealthy_total (unhealthy_total),
		.failed_total    (failed_total)
	);

endmodule

FILE: tb/sv/tb_component_health_breaker_table_unit.sv
`timescale 1ns / 1ps

module tb_component_health_breaker_table_unit;
	import chbt_pkg::*;

	localparam logic [2:0] OP_UNDEFINED = 3'd7;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned RANDOM_PER_PHASE = 400;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  comp;
		logic [31:0] now;
		logic [2:0]  forced;
	} hb_event_t;

	typedef struct packed {
		logic       id_valid;
		logic       allowed;
		logic [2:0] health;
		logic [1:0] circuit;
		logic [7:0] streak;
		logic [2:0] overall;
		logic       control;
		logic       observe;
		logic [3:0] n_healthy;
		logic [3:0] n_degraded;
		logic [3:0] n_unhealthy;
		logic [3:0] n_failed;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [3:0]  component = '0;
	logic [31:0] now_ms = '0;
	logic [2:0]  forced_health = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        id_valid;
	logic        allowed;
	logic [2:0]  comp_health;
	logic [1:0]  comp_circuit;
	logic [7:0]  fail_streak;
	logic [2:0]  overall_health;
	logic        control_ok;
	logic        observe_ok;
	logic [3:0]  healthy_total;
	logic [3:0]  degraded_total;
	logic [3:0]  unhealthy_total;
	logic [3:0]  failed_total;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// model copy of the tables and configuration
	cfg_t        settings;
	health_t     healths [DEF_COMPONENTS];
	circuit_t    breakers[DEF_COMPONENTS];
	logic [7:0]  streaks [DEF_COMPONENTS];
	logic [31:0] fail_at [DEF_COMPONENTS];
	bit          ready_flag[DEF_COMPONENTS];

	hb_event_t   pending_events[$];
	verdict_t    due_verdicts[$];
	logic        word_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	logic [31:0] clock_ms;

	component_health_breaker_table_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.component(component),
		.now_ms(now_ms),
		.forced_health(forced_health),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.id_valid(id_valid),
		.allowed(allowed),
		.comp_health(comp_health),
		.comp_circuit(comp_circuit),
		.fail_streak(fail_streak),
		.overall_health(overall_health),
		.control_ok(control_ok),
		.observe_ok(observe_ok),
		.healthy_total(healthy_total),
		.degraded_total(degraded_total),
		.unhealthy_total(unhealthy_total),
		.failed_total(failed_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic verdict_t apply_event(hb_event_t ev);
		verdict_t    v;
		int unsigned c;
		logic [5:0]  thr;
		logic [15:0] tmo;
		logic [31:0] elapsed;
		v = '0;
		v.overall = H_HEALTHY;
		v.control = 1'b1;
		v.observe = 1'b1;
		c = 32'(ev.comp);
		if (c < DEF_COMPONENTS) begin
			thr = settings.thresholds[6*c +: 6];
			if (thr == '0)
				thr = DEFAULT_THRESHOLD;
			if (c < 4)
				tmo = settings.timeouts_low[16*c +: 16];
			else if (c < 8)
				tmo = settings.timeouts_high[16*(c-4) +: 16];
			else
				tmo = settings.timeout_last;
			if (tmo == '0)
				tmo = DEFAULT_TIMEOUT;
			case (ev.op)
				OP_SUCCESS: begin
					streaks[c] = '0;
					if (healths[c] == H_UNHEALTHY || healths[c] == H_UNKNOWN)
						healths[c] = H_HEALTHY;
					if (breakers[c] == C_HALF)
						breakers[c] = C_CLOSED;
				end
				OP_FAILURE: begin
					if (streaks[c] != '1)
						streaks[c] = streaks[c] + 8'd1;
					fail_at[c] = ev.now;
					if (streaks[c] >= 8'(thr)) begin
						if (healths[c] != H_FAILED) begin
							healths[c] = H_UNHEALTHY;
							if (breakers[c] == C_CLOSED)
								breakers[c] = C_OPEN;
						end
					end else if (healths[c] == H_HEALTHY) begin
						healths[c] = H_DEGRADED;
					end
					if (breakers[c] == C_HALF)
						breakers[c] = C_OPEN;
				end
				OP_ALLOW: begin
					if (breakers[c] == C_CLOSED) begin
						v.allowed = 1'b1;
					end else if (breakers[c] == C_OPEN) begin
						// wrapping time difference
						elapsed = ev.now - fail_at[c];
						if (elapsed >= 32'(tmo)) begin
							breakers[c] = C_HALF;
							v.allowed = 1'b1;
						end
					end
				end
				OP_RESET: begin
					breakers[c] = C_CLOSED;
					streaks[c] = '0;
				end
				OP_INIT: begin
					ready_flag[c] = 1'b1;
					if (healths[c] == H_UNKNOWN)
						healths[c] = H_HEALTHY;
				end
				OP_FORCE: begin
					if (ev.forced <= H_FAILED)
						healths[c] = health_t'(ev.forced);
				end
				default: begin
				end
			endcase
			v.id_valid = 1'b1;
			v.health = healths[c];
			v.circuit = breakers[c];
			v.streak = streaks[c];
		end else begin
			v.circuit = C_OPEN;
		end
		for (int i = 0; i < DEF_COMPONENTS; i++) begin
			if (ready_flag[i] && healths[i] != H_UNKNOWN) begin
				case (healths[i])
					H_HEALTHY: v.n_healthy = v.n_healthy + 4'd1;
					H_DEGRADED: v.n_degraded = v.n_degraded + 4'd1;
					H_UNHEALTHY: v.n_unhealthy = v.n_unhealthy + 4'd1;
					default: v.n_failed = v.n_failed + 4'd1;
				endcase
				if (healths[i] > v.overall)
					v.overall = healths[i];
				if (settings.critical_mask[i] && healths[i] >= H_UNHEALTHY)
					v.control = 1'b0;
				if (settings.critical_mask[i] && healths[i] == H_FAILED)
					v.observe = 1'b0;
			end
		end
		return v;
	endfunction

	function automatic hb_event_t random_event();
		hb_event_t   ev;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			ev.op = OP_SUCCESS;
		else if (r < 45)
			ev.op = OP_FAILURE;
		else if (r < 70)
			ev.op = OP_ALLOW;
		else if (r < 75)
			ev.op = OP_RESET;
		else if (r < 83)
			ev.op = OP_INIT;
		else if (r < 93)
			ev.op = OP_FORCE;
		else if (r < 97)
			ev.op = OP_QUERY;
		else
			ev.op = OP_UNDEFINED;
		if ($urandom_range(99) < 90)
			ev.comp = 4'($urandom_range(0, DEF_COMPONENTS - 1));
		else
			ev.comp = 4'($urandom_range(DEF_COMPONENTS, 15));
		r = $urandom_range(99);
		if (r < 85)
			clock_ms = clock_ms + $urandom_range(0, 3000);
		else if (r < 95)
			clock_ms = $urandom();
		ev.now = (r >= 97) ? 32'($urandom()) : clock_ms;
		if ($urandom_range(99) < 85)
			ev.forced = 3'($urandom_range(H_UNKNOWN, H_FAILED));
		else
			ev.forced = 3'($urandom_range(H_FAILED + 1, 7));
		return ev;
	endfunction

	function automatic logic [63:0] short_timeouts();
		logic [63:0] w;
		for (int i = 0; i < 4; i++)
			w[16*i +: 16] = 16'($urandom_range(1, 2500));
		return w;
	endfunction

	task automatic push_event(logic [2:0] o, logic [3:0] c, logic [31:0] t, logic [2:0] f);
		hb_event_t ev;
		ev.op = o;
		ev.comp = c;
		ev.now = t;
		ev.forced = f;
		pending_events.push_back(ev);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_CRITICAL_MASK: settings.critical_mask = data[8:0];
			CFG_THRESHOLDS: settings.thresholds = data[53:0];
			CFG_TIMEOUTS_LOW: settings.timeouts_low = data;
			CFG_TIMEOUTS_HIGH: settings.timeouts_high = data;
			default: settings.timeout_last = data[15:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_events.size() != 0 || in_valid || due_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		hb_event_t nxt;
		if (arst_n) begin
			if (!in_valid || word_taken) begin
				if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_events.pop_front();
					in_valid <= 1'b1;
					op <= nxt.op;
					component <= nxt.comp;
					now_ms <= nxt.now;
					forced_health <= nxt.forced;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		hb_event_t seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {id_valid, allowed, comp_health, comp_circuit, fail_streak,
					overall_health, control_ok, observe_ok, healthy_total,
					degraded_total, unhealthy_total, failed_total};
				if (due_verdicts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result word: %p", got);
				end else begin
					want = due_verdicts.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				seen = {op, component, now_ms, forced_health};
				due_verdicts.push_back(apply_event(seen));
			end
			word_taken <= in_valid && !in_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_component_health_breaker_table_unit: done, errors");
		$finish;
	end

	initial begin
		logic [63:0] w;
		int unsigned b;
		settings.critical_mask = 9'h00F;
		settings.thresholds = 54'd857828500451523;
		settings.timeouts_low = 64'h7530_7530_7530_7530;
		settings.timeouts_high = 64'h7530_7530_7530_7530;
		settings.timeout_last = DEFAULT_TIMEOUT;
		for (int i = 0; i < DEF_COMPONENTS; i++) begin
			healths[i] = H_UNKNOWN;
			breakers[i] = C_CLOSED;
			streaks[i] = '0;
			fail_at[i] = '0;
			ready_flag[i] = 1'b0;
		end
		clock_ms = $urandom();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset configuration, no idling
		push_event(OP_QUERY, 4'd0, 32'h0, H_UNKNOWN);
		push_event(OP_UNDEFINED, 4'd1, 32'hFFFF_FFFF, 3'd7);
		push_event(OP_SUCCESS, 4'd9, 32'h0, H_UNKNOWN);
		push_event(OP_FAILURE, 4'd15, 32'hFFFF_FFFF, H_FAILED);
		push_event(OP_INIT, 4'd15, 32'h0, H_UNKNOWN);
		push_event(OP_SUCCESS, 4'd8, 32'h0, H_UNKNOWN);
		push_event(OP_INIT, 4'd0, 32'h0, H_UNKNOWN);
		push_event(OP_INIT, 4'd1, 32'h0, H_UNKNOWN);
		push_event(OP_INIT, 4'd2, 32'h0, H_UNKNOWN);
		push_event(OP_INIT, 4'd8, 32'h0, H_UNKNOWN);
		repeat (3) push_event(OP_FAILURE, 4'd0, 32'hFFFF_FFF0, H_UNKNOWN);
		// timeout measured across the time wrap
		push_event(OP_ALLOW, 4'd0, 32'h0000_0010, H_UNKNOWN);
		push_event(OP_ALLOW, 4'd0, 32'h0000_7520, H_UNKNOWN);
		push_event(OP_ALLOW, 4'd0, 32'h0000_7520, H_UNKNOWN);
		push_event(OP_FAILURE, 4'd0, 32'h0000_7600, H_UNKNOWN);
		push_event(OP_ALLOW, 4'd1, 32'h0000_7600, H_UNKNOWN);
		push_event(OP_RESET, 4'd0, 32'h0000_7600, H_UNKNOWN);
		push_event(OP_FORCE, 4'd1, 32'h0, H_FAILED);
		push_event(OP_FORCE, 4'd1, 32'h0, 3'd5);
		push_event(OP_FORCE, 4'd1, 32'h0, 3'd7);
		push_event(OP_FAILURE, 4'd1, 32'h0000_8000, H_UNKNOWN);
		push_event(OP_FORCE, 4'd2, 32'h0, H_UNKNOWN);
		push_event(OP_FORCE, 4'd8, 32'h0, H_UNHEALTHY);
		push_event(OP_SUCCESS, 4'd0, 32'h0000_8000, H_UNKNOWN);
		repeat (RANDOM_PER_PHASE) pending_events.push_back(random_event());
		drain();

		// all critical, maximum thresholds, sender gaps
		send_idle_pct = 49;
		stall_pct = 0;
		write_reg(CFG_CRITICAL_MASK, 64'h1FF);
		write_reg(CFG_THRESHOLDS, {10'h0, {54{1'b1}}});
		write_reg(CFG_TIMEOUTS_LOW, 64'h0);
		write_reg(CFG_TIMEOUTS_HIGH, short_timeouts());
		write_reg(CFG_TIMEOUT_LAST, 64'hFFFF);
		// long failure run drives the streak into saturation
		b = $urandom_range(0, DEF_COMPONENTS - 1);
		push_event(OP_INIT, 4'(b), clock_ms, H_UNKNOWN);
		repeat (260) begin
			clock_ms = clock_ms + $urandom_range(0, 50);
			push_event(OP_FAILURE, 4'(b), clock_ms, H_UNKNOWN);
		end
		push_event(OP_RESET, 4'(b), clock_ms, H_UNKNOWN);
		repeat (RANDOM_PER_PHASE) pending_events.push_back(random_event());
		drain();

		// nothing critical, default thresholds, receiver stalls
		send_idle_pct = 0;
		stall_pct = 49;
		write_reg(CFG_CRITICAL_MASK, 64'h0);
		write_reg(CFG_THRESHOLDS, 64'h0);
		write_reg(CFG_TIMEOUTS_LOW, short_timeouts());
		write_reg(CFG_TIMEOUTS_HIGH, short_timeouts());
		write_reg(CFG_TIMEOUT_LAST, 64'h1);
		repeat (RANDOM_PER_PHASE) pending_events.push_back(random_event());
		drain();

		// mixed settings, both sides idle
		send_idle_pct = 20;
		stall_pct = 20;
		write_reg(CFG_CRITICAL_MASK, 64'($urandom_range(0, 511)));
		w = '0;
		for (int i = 0; i < DEF_COMPONENTS; i++)
			w[6*i +: 6] = 6'($urandom_range(0, 6));
		write_reg(CFG_THRESHOLDS, w);
		write_reg(CFG_TIMEOUTS_LOW, short_timeouts());
		write_reg(CFG_TIMEOUTS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_TIMEOUT_LAST, 64'($urandom_range(1, 3000)));
		repeat (RANDOM_PER_PHASE) pending_events.push_back(random_event());
		drain();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_component_health_breaker_table_unit: done, clean");
		else
			$display("tb_component_health_breaker_table_unit: done, errors");
		$finish;
	end

endmodule
